>>> rtl/core/dlps_pkg.sv
// ----------------------------------------------------------------------------
// dlps_pkg: shared types and constants of the delay line pitch shifter
// Payload structs, configuration register indexes, the state type of the
// sequencer and small rounding and saturation helpers.
// ----------------------------------------------------------------------------
package dlps_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int STORE_BITS  = SAMPLE_BITS + 4;
    localparam int GAIN_W      = 17;
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_INDEX_W = 3;

    localparam logic [GAIN_W-1:0] UNITY = 17'd65536;

    localparam int STORE_MAX  = (1 << (STORE_BITS - 1)) - 1;
    localparam int STORE_MIN  = -(1 << (STORE_BITS - 1));
    localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_BITS - 1));

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_RATIO   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_GAIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WET_MIX       = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_left;
        logic signed [SAMPLE_BITS-1:0] sample_right;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } out_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX_MUL,
        ST_MIX_ADD,
        ST_DIV,
        ST_WRITE,
        ST_POS1,
        ST_POS2,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_W,
        ST_I_A,
        ST_I_B,
        ST_I_SUM,
        ST_SPLICE,
        ST_X_A,
        ST_X_B,
        ST_X_SUM,
        ST_TRIM,
        ST_TRIM_RND,
        ST_MIX_W,
        ST_MIX_D,
        ST_OUT_SUM,
        ST_PUSH
    } state_t;

    // round a Q16 product to nearest, halves up
    function automatic logic signed [31:0] round_q16(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = v + 48'sd32768;
        return 32'(t >>> 16);
    endfunction

    function automatic logic signed [STORE_BITS-1:0] sat_store(input logic signed [31:0] v);
        logic signed [STORE_BITS-1:0] r;
        if (v > STORE_MAX)
            r = STORE_BITS'(STORE_MAX);
        else if (v < STORE_MIN)
            r = STORE_BITS'(STORE_MIN);
        else
            r = v[STORE_BITS-1:0];
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [31:0] v);
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAMPLE_MAX)
            r = SAMPLE_BITS'(SAMPLE_MAX);
        else if (v < SAMPLE_MIN)
            r = SAMPLE_BITS'(SAMPLE_MIN);
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] clamp_unity(input logic [GAIN_W-1:0] g);
        return (g > UNITY) ? UNITY : g;
    endfunction

endpackage

>>> rtl/core/dlps_ram.sv
// ----------------------------------------------------------------------------
// dlps_ram: generic single clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dlps_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/dlps_div.sv
// ----------------------------------------------------------------------------
// dlps_div: restoring unsigned divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module dlps_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg, quo_reg[NUM_W-1]};
        ge        = (rem_sh >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // shift in the next numerator bit, subtract where it fits
            rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> rtl/core/delay_line_pitch_shifter.sv
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter: stereo delay line pitch shifter with feedback
// Circular window per channel in RAM, fractional read with interpolation,
// splice crossfade, output trim and dry/wet mix.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_ready/in_data carry one stereo sample pair per transaction;
//   out_valid/out_ready/out_data return exactly one stereo result for each.
//   cfg_en/cfg_index/cfg_data write a register (0 speed ratio,
//   1 window length, 2 feedback gain, 3 output gain, 4 wet mix); write only
//   while no transaction is in flight.
// Operation
//   One pair is worked at a time by a sequencer around a single 29x18
//   multiplier and the two window RAMs; the next pair is taken only once
//   the last result has been handed to the output register.
//   When a channel's feedback exceeds full scale its sum is normalised by a
//   bit-serial divider.
// Reset
//   After rst_n releases, both windows are swept to zero, one entry per
//   cycle, over all WINDOW_DEPTH entries; in_ready stays low meanwhile while
//   configuration writes are taken as usual.
// Stalls
//   A finished result waits in the output register; the next pair is taken
//   and worked meanwhile, and only its hand-over waits for out_ready.
// WINDOW_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter
    import dlps_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16384
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_t                   out_data,
    input  logic                   cfg_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW      = $clog2(WINDOW_DEPTH);
    localparam int LIMIT   = (9990 < WINDOW_DEPTH - 2) ? 9990 : WINDOW_DEPTH - 2;
    localparam logic [21:0] W_MAX = 22'(LIMIT * 256);
    localparam logic [21:0] W_MIN = 22'd256;
    localparam int CMP_W   = (AW + 17 > 30) ? AW + 17 : 30;
    localparam int RW      = (AW + 9 > 22) ? AW + 9 : 22;
    localparam int IW      = 17;
    localparam int MA_W    = STORE_BITS + 1;
    localparam int P_W     = MA_W + 18;
    localparam int X_W     = STORE_BITS + 1;
    localparam int NUM_W   = X_W + SAMPLE_BITS - 1;
    localparam logic [STORE_BITS-1:0] FS_MAG = STORE_BITS'(1) << (SAMPLE_BITS - 1);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic   ch_reg, ch_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic [18:0] speed_reg, speed_next;
    logic [21:0] wlen_reg, wlen_next;
    logic [GAIN_W-1:0] fbg_reg, fbg_next;
    logic [GAIN_W-1:0] outg_reg, outg_next;
    logic [GAIN_W-1:0] wet_reg, wet_next;

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW:0]   wp1_reg, wp1_next;
    logic [29:0]   rp_reg, rp_next;
    logic [29:0]   rp1_reg, rp1_next;
    logic          pend_reg, pend_next;
    logic [GAIN_W-1:0] amt_reg [2];
    logic [GAIN_W-1:0] amt_next [2];
    logic signed [STORE_BITS-1:0] fb_reg [2];
    logic signed [STORE_BITS-1:0] fb_next [2];
    logic out_valid_reg, out_valid_next;

    // datapath, no reset
    logic signed [SAMPLE_BITS-1:0] dry_reg [2];
    logic signed [SAMPLE_BITS-1:0] dry_next [2];
    logic signed [STORE_BITS-1:0]  mixed_reg [2];
    logic signed [STORE_BITS-1:0]  mixed_next [2];
    logic signed [STORE_BITS-1:0]  ra_reg [2];
    logic signed [STORE_BITS-1:0]  ra_next [2];
    logic signed [STORE_BITS-1:0]  rb_reg [2];
    logic signed [STORE_BITS-1:0]  rb_next [2];
    logic signed [STORE_BITS-1:0]  rc_reg [2];
    logic signed [STORE_BITS-1:0]  rc_next [2];
    logic signed [P_W-1:0] p_reg, p_next;
    logic signed [P_W-1:0] acc_reg, acc_next;
    logic signed [STORE_BITS-1:0] s_reg, s_next;
    logic signed [STORE_BITS-1:0] yv_reg, yv_next;
    logic signed [SAMPLE_BITS-1:0] resl_reg, resl_next;
    logic signed [SAMPLE_BITS-1:0] resr_reg, resr_next;
    logic xneg_reg, xneg_next;
    out_t out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [21:0] w_clamp;
    logic [AW-1:0] aw_len;
    logic [IW-1:0] c_a, c_b;
    logic [AW-1:0] idx_a, idx_b;
    logic [15:0] frac;
    logic signed [MA_W-1:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [P_W:0] sum_w;
    logic signed [31:0] sum_rnd;
    logic signed [31:0] p_rnd;
    logic signed [X_W-1:0] x_mix;
    logic [X_W-1:0] x_abs;
    logic [STORE_BITS-1:0] fb_mag;
    logic signed [X_W:0] q_signed;
    logic [CMP_W-1:0] cmp_rp, cmp_wp;
    logic [RW-1:0] wp8, w_ext, wp_diff;
    logic [AW:0] wp_red;
    logic [29:0] w_shift;
    logic [X_W-1:0] d_diff;
    logic [X_W-1:0] d_abs;
    logic [46:0] sp_lhs, sp_rhs;
    logic [22:0] sp_n;
    logic [GAIN_W-1:0] fg, tg, wg;
    logic [GAIN_W-1:0] one_m_frac, one_m_amt, one_m_wg;

    // RAM and divider connections
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [STORE_BITS-1:0] wdata_l, wdata_r, rdata_l, rdata_r;
    logic div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quot;

    function automatic logic [AW-1:0] map_idx(input logic [IW-1:0] c,
                                               input logic [AW-1:0] len);
        logic [IW-1:0] r;
        r = c;
        if (c > IW'(len))
            r = c - IW'(len) - 1'b1;
        return r[AW-1:0];
    endfunction

    always_comb
    begin
        // window length clamp, integer part and read indices
        if (wlen_reg < W_MIN)
            w_clamp = W_MIN;
        else if (wlen_reg > W_MAX)
            w_clamp = W_MAX;
        else
            w_clamp = wlen_reg;
        aw_len = AW'(w_clamp[21:8]);
        c_a    = IW'(rp_reg[29:16]);
        c_b    = c_a + 1'b1;
        idx_a  = map_idx(c_a, aw_len);
        idx_b  = map_idx(c_b, aw_len);
        frac   = rp_reg[15:0];

        fg = clamp_unity(fbg_reg);
        tg = clamp_unity(outg_reg);
        wg = clamp_unity(wet_reg);
        one_m_frac = UNITY - GAIN_W'(frac);
        one_m_amt  = UNITY - amt_reg[ch_reg];
        one_m_wg   = UNITY - wg;

        // shared adder and rounding
        sum_w   = {acc_reg[P_W-1], acc_reg} + {p_reg[P_W-1], p_reg};
        sum_rnd = round_q16(48'(sum_w));
        p_rnd   = round_q16(48'(p_reg));

        // feedback mix of the current channel
        x_mix  = X_W'(dry_reg[ch_reg]) + X_W'(p_rnd);
        x_abs  = x_mix[X_W-1] ? X_W'(-x_mix) : X_W'(x_mix);
        fb_mag = fb_reg[ch_reg][STORE_BITS-1] ? STORE_BITS'(-fb_reg[ch_reg])
                                                : STORE_BITS'(fb_reg[ch_reg]);
        q_signed = xneg_reg ? -$signed({1'b0, div_quot[X_W-1:0]})
                            : $signed({1'b0, div_quot[X_W-1:0]});
        div_num  = {x_abs, (SAMPLE_BITS - 1)'(0)};

        // position arithmetic
        cmp_rp  = CMP_W'(rp1_reg);
        cmp_wp  = CMP_W'({wp1_reg, 16'b0});
        wp8     = RW'({wp1_reg, 8'b0});
        w_ext   = RW'(w_clamp);
        wp_diff = wp8 - w_ext;
        wp_red  = (wp8 > w_ext) ? wp_diff[AW+8:8] : wp1_reg;
        w_shift = {w_clamp, 8'b0};

        // splice smoothing
        d_diff = X_W'(s_reg) - X_W'(rc_reg[ch_reg]);
        d_abs  = d_diff[X_W-1] ? X_W'(-d_diff) : d_diff;
        sp_lhs = 47'({amt_reg[ch_reg], (SAMPLE_BITS - 1)'(0)});
        sp_rhs = 47'({d_abs, 17'b0});
        sp_n   = 23'(amt_reg[ch_reg] >> 1)
               + 23'(47'({d_abs, 16'b0}) >> (SAMPLE_BITS - 1));
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        clr_next       = clr_reg;
        speed_next     = speed_reg;
        wlen_next      = wlen_reg;
        fbg_next       = fbg_reg;
        outg_next      = outg_reg;
        wet_next       = wet_reg;
        wp_next        = wp_reg;
        wp1_next       = wp1_reg;
        rp_next        = rp_reg;
        rp1_next       = rp1_reg;
        pend_next      = pend_reg;
        amt_next       = amt_reg;
        fb_next        = fb_reg;
        out_valid_next = out_valid_reg;
        dry_next       = dry_reg;
        mixed_next     = mixed_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        rc_next        = rc_reg;
        acc_next       = acc_reg;
        s_next         = s_reg;
        yv_next        = yv_reg;
        resl_next      = resl_reg;
        resr_next      = resr_reg;
        xneg_next      = xneg_reg;
        out_data_next  = out_data_reg;

        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        wdata_l   = mixed_reg[0];
        wdata_r   = mixed_reg[1];
        ram_raddr = wp_reg;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;

        // drop the result once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cfg_en)
        begin
            case (cfg_index)
                CFG_SPEED_RATIO:   speed_next = cfg_data[18:0];
                CFG_WINDOW_LENGTH: wlen_next  = cfg_data;
                CFG_FEEDBACK_GAIN: fbg_next   = cfg_data[GAIN_W-1:0];
                CFG_OUTPUT_GAIN:   outg_next  = cfg_data[GAIN_W-1:0];
                CFG_WET_MIX:       wet_next   = cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                wdata_l   = '0;
                wdata_r   = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(WINDOW_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dry_next[0] = in_data.sample_left;
                    dry_next[1] = in_data.sample_right;
                    ch_next     = 1'b0;
                    state_next  = ST_MIX_MUL;
                end
            end
            ST_MIX_MUL:
            begin
                mul_a      = MA_W'(fb_reg[ch_reg]);
                mul_b      = {1'b0, fg};
                state_next = ST_MIX_ADD;
            end
            ST_MIX_ADD:
            begin
                if (fb_mag > FS_MAG)
                begin
                    // normalise by the feedback magnitude
                    div_start  = 1'b1;
                    xneg_next  = x_mix[X_W-1];
                    state_next = ST_DIV;
                end
                else
                begin
                    mixed_next[ch_reg] = sat_store(32'(x_mix));
                    ch_next    = ~ch_reg;
                    state_next = ch_reg ? ST_WRITE : ST_MIX_MUL;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mixed_next[ch_reg] = sat_store(32'(q_signed));
                    ch_next    = ~ch_reg;
                    state_next = ch_reg ? ST_WRITE : ST_MIX_MUL;
                end
            end
            ST_WRITE:
            begin
                ram_we     = 1'b1;
                state_next = ST_POS1;
            end
            ST_POS1:
            begin
                wp1_next   = (AW + 1)'(wp_reg) + 1'b1;
                rp1_next   = rp_reg + 30'(speed_reg);
                state_next = ST_POS2;
            end
            ST_POS2:
            begin
                pend_next = pend_reg;
                if ((cmp_rp > cmp_wp) && pend_reg)
                begin
                    amt_next[0] = UNITY;
                    amt_next[1] = UNITY;
                    pend_next   = 1'b0;
                end
                wp_next = wp_red[AW] ? '0 : wp_red[AW-1:0];
                if (rp1_reg > w_shift)
                begin
                    rp_next   = rp1_reg - w_shift;
                    pend_next = 1'b1;
                end
                else
                    rp_next = rp1_reg;
                state_next = ST_RD_A;
            end
            ST_RD_A:
            begin
                ram_raddr  = idx_a;
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                ram_raddr  = idx_b;
                ra_next[0] = rdata_l;
                ra_next[1] = rdata_r;
                state_next = ST_RD_C;
            end
            ST_RD_C:
            begin
                ram_raddr  = wp_reg;
                rb_next[0] = rdata_l;
                rb_next[1] = rdata_r;
                state_next = ST_RD_W;
            end
            ST_RD_W:
            begin
                rc_next[0] = rdata_l;
                rc_next[1] = rdata_r;
                ch_next    = 1'b0;
                state_next = ST_I_A;
            end
            ST_I_A:
            begin
                mul_a      = MA_W'(ra_reg[ch_reg]);
                mul_b      = {1'b0, one_m_frac};
                state_next = ST_I_B;
            end
            ST_I_B:
            begin
                acc_next   = p_reg;
                mul_a      = MA_W'(rb_reg[ch_reg]);
                mul_b      = {2'b00, frac};
                state_next = ST_I_SUM;
            end
            ST_I_SUM:
            begin
                s_next     = STORE_BITS'(sum_rnd);
                state_next = ST_SPLICE;
            end
            ST_SPLICE:
            begin
                // decay the crossfade toward the interpolated sample
                if (sp_lhs > sp_rhs)
                    amt_next[ch_reg] = (sp_n > 23'(UNITY)) ? UNITY : GAIN_W'(sp_n);
                state_next = ST_X_A;
            end
            ST_X_A:
            begin
                mul_a      = MA_W'(rc_reg[ch_reg]);
                mul_b      = {1'b0, amt_reg[ch_reg]};
                state_next = ST_X_B;
            end
            ST_X_B:
            begin
                acc_next   = p_reg;
                mul_a      = MA_W'(s_reg);
                mul_b      = {1'b0, one_m_amt};
                state_next = ST_X_SUM;
            end
            ST_X_SUM:
            begin
                fb_next[ch_reg] = sat_store(sum_rnd);
                state_next      = ST_TRIM;
            end
            ST_TRIM:
            begin
                mul_a      = MA_W'(fb_reg[ch_reg]);
                mul_b      = {1'b0, tg};
                state_next = ST_TRIM_RND;
            end
            ST_TRIM_RND:
            begin
                yv_next    = STORE_BITS'(p_rnd);
                state_next = ST_MIX_W;
            end
            ST_MIX_W:
            begin
                mul_a      = MA_W'(yv_reg);
                mul_b      = {1'b0, wg};
                state_next = ST_MIX_D;
            end
            ST_MIX_D:
            begin
                acc_next   = p_reg;
                mul_a      = MA_W'(dry_reg[ch_reg]);
                mul_b      = {1'b0, one_m_wg};
                state_next = ST_OUT_SUM;
            end
            ST_OUT_SUM:
            begin
                if (!ch_reg)
                begin
                    resl_next  = sat_sample(sum_rnd);
                    ch_next    = 1'b1;
                    state_next = ST_I_A;
                end
                else
                begin
                    resr_next  = sat_sample(sum_rnd);
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // hold the finished pair until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.out_left  = resl_reg;
                    out_data_next.out_right = resr_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        p_next = P_W'(mul_a * mul_b);
    end

    // out_data_reg is loaded only at the hand-over in ST_PUSH
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ch_reg        <= 1'b0;
            clr_reg       <= '0;
            speed_reg     <= 19'd65536;
            wlen_reg      <= 22'd46972;
            fbg_reg       <= '0;
            outg_reg      <= UNITY;
            wet_reg       <= UNITY;
            wp_reg        <= AW'(1);
            wp1_reg       <= '0;
            rp_reg        <= 30'd65536;
            rp1_reg       <= '0;
            pend_reg      <= 1'b0;
            amt_reg[0]    <= '0;
            amt_reg[1]    <= '0;
            fb_reg[0]     <= '0;
            fb_reg[1]     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            clr_reg       <= clr_next;
            speed_reg     <= speed_next;
            wlen_reg      <= wlen_next;
            fbg_reg       <= fbg_next;
            outg_reg      <= outg_next;
            wet_reg       <= wet_next;
            wp_reg        <= wp_next;
            wp1_reg       <= wp1_next;
            rp_reg        <= rp_next;
            rp1_reg       <= rp1_next;
            pend_reg      <= pend_next;
            amt_reg       <= amt_next;
            fb_reg        <= fb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dry_reg      <= dry_next;
        mixed_reg    <= mixed_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        rc_reg       <= rc_next;
        p_reg        <= p_next;
        acc_reg      <= acc_next;
        s_reg        <= s_next;
        yv_reg       <= yv_next;
        resl_reg     <= resl_next;
        resr_reg     <= resr_next;
        xneg_reg     <= xneg_next;
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // window memories and the normalising divider
    // ------------------------------------------------------------------
    dlps_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_win_left (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wdata_l),
        .raddr (ram_raddr),
        .rdata (rdata_l)
    );

    dlps_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_win_right (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wdata_r),
        .raddr (ram_raddr),
        .rdata (rdata_r)
    );

    dlps_div #(
        .NUM_W (NUM_W),
        .DEN_W (STORE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (fb_mag),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
